@@ hdl/crs_pkg.sv @@
// crs_pkg: shared types and constants for the column run segmenter.
// No dependencies; imported by every module under hdl/.
package crs_pkg;

  localparam int unsigned MaxRunsDefault = 16;
  localparam int unsigned RunCountCap    = 31;

  localparam logic [7:0]  ColumnHeightRst = 8'd127;
  localparam logic [10:0] ImageWidthRst   = 11'd150;
  localparam logic [10:0] ColumnIndexMax  = 11'd1023;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgColumnHeight = 2'd0,
    CfgImageWidth   = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  column_height;
    logic [10:0] image_width;
  } cfg_t;

  // one finished run as it leaves the tracker
  typedef struct packed {
    logic [9:0] column_index;
    logic [3:0] run_index;
    logic [7:0] run_bottom;
    logic [7:0] run_top;
    logic       run_overflow;
    logic [4:0] max_runs_seen;
  } run_word_t;

endpackage

@@ hdl/column_run_segmenter.sv @@
// column_run_segmenter: vertical run-length segmentation, one pixel per word.
// A pixel that closes a run waits in the input register, then its run word is registered in
// the result register. Throughput: 1 pixel per cycle while the result register is free; each
// pixel's update is one short pass from input register through the run tracker to result register.
// Reset (rst_ni low, async): valid flags and run state cleared, height 127, width 150; pixel/word data not reset.
// Depends on crs_pkg, crs_cfg_regs, crs_run_tracker, crs_out_reg.
module column_run_segmenter #(
  parameter int unsigned MAX_RUNS = crs_pkg::MaxRunsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        pixel_on_i,
  // run output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  column_index_o,
  output logic [3:0]  run_index_o,
  output logic [7:0]  run_bottom_o,
  output logic [7:0]  run_top_o,
  output logic        run_overflow_o,
  output logic [4:0]  max_runs_seen_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import crs_pkg::*;

  cfg_t      cfg;
  run_word_t trk_word, out_word;
  logic      trk_emit;
  logic      out_free;

  // input register: holds one pixel until the tracker can retire it
  logic s1_valid_q, s1_valid_d;
  logic s1_pixel_q;
  logic in_accept;
  logic advance;

  crs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // A pixel in the input register retires when it closes no run, or when the
  // result register can take the run word this cycle.
  assign advance    = s1_valid_q && (!trk_emit || out_free);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pixel_on_i;
    end
  end

  crs_run_tracker #(
    .MAX_RUNS (MAX_RUNS)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pixel_on_i (s1_pixel_q),
    .step_i     (advance),
    .emit_o     (trk_emit),
    .word_o     (trk_word)
  );

  crs_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && trk_emit),
    .word_i      (trk_word),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .word_o      (out_word)
  );

  assign column_index_o  = out_word.column_index;
  assign run_index_o     = out_word.run_index;
  assign run_bottom_o    = out_word.run_bottom;
  assign run_top_o       = out_word.run_top;
  assign run_overflow_o  = out_word.run_overflow;
  assign max_runs_seen_o = out_word.max_runs_seen;

  // a held run word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i && advance && trk_emit))
    else $error("run word overwritten while stalled");

  // stall only ever comes from a pixel parked in the input register
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && trk_emit && !out_free))
    else $error("input stalled without a blocked run word");

  // a run never ends below the row where it started
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_bottom_o <= run_top_o))
    else $error("run top below run bottom");

endmodule

@@ hdl/crs_cfg_regs.sv @@
// crs_cfg_regs: configuration register file (column height, image width).
// Depends on crs_pkg.
module crs_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i,
  output logic              cfg_ready_o,
  output crs_pkg::cfg_t     cfg_o
);
  import crs_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgColumnHeight: cfg_d.column_height = cfg_data_i[7:0];
        CfgImageWidth:   cfg_d.image_width   = cfg_data_i;
        default: ;  // writes to unmapped indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_height <= ColumnHeightRst;
      cfg_q.image_width   <= ImageWidthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/crs_run_tracker.sv @@
// crs_run_tracker: per-pixel run state (row, column, open run, counts).
// Depends on crs_pkg. Produces at most one run word per pixel, combinationally.
module crs_run_tracker #(
  parameter int unsigned MAX_RUNS = crs_pkg::MaxRunsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crs_pkg::cfg_t      cfg_i,
  input  logic               pixel_on_i,
  input  logic               step_i,
  output logic               emit_o,
  output crs_pkg::run_word_t word_o
);
  import crs_pkg::*;

  localparam logic [6:0] OrdMax  = 7'(MAX_RUNS - 1);
  localparam logic [6:0] OvfLim  = 7'(MAX_RUNS);
  localparam logic [4:0] CntCap  = 5'(RunCountCap);
  localparam logic [4:0] MaxCap  = (MAX_RUNS > RunCountCap) ? 5'(RunCountCap) : 5'(MAX_RUNS);

  logic [7:0] row_q, row_d;
  logic [9:0] col_q, col_d;
  logic       in_run_q, in_run_d;
  logic [7:0] start_q, start_d;
  logic [4:0] runs_q, runs_d;
  logic [4:0] max_q, max_d;

  logic [7:0]  last_row;
  logic        col_end;
  logic        opening;
  logic [7:0]  start_eff;
  logic [6:0]  ord;
  logic [4:0]  cnt, cnt_cap, max_new;
  logic [10:0] col_next;
  logic        col_wrap;

  assign last_row  = (cfg_i.column_height == 8'd0) ? 8'd0 : cfg_i.column_height - 8'd1;
  assign col_end   = row_q >= last_row;
  assign opening   = pixel_on_i && !in_run_q;
  assign start_eff = opening ? row_q : start_q;
  assign emit_o    = pixel_on_i ? col_end : in_run_q;

  assign ord     = ({2'b00, runs_q} > OrdMax) ? OrdMax : {2'b00, runs_q};
  assign cnt     = (runs_q == CntCap) ? CntCap : runs_q + 5'd1;
  assign cnt_cap = (cnt > MaxCap) ? MaxCap : cnt;
  assign max_new = (cnt_cap > max_q) ? cnt_cap : max_q;

  assign col_next = {1'b0, col_q} + 11'd1;
  assign col_wrap = (col_next >= cfg_i.image_width) || (col_next > ColumnIndexMax);

  always_comb begin
    word_o.column_index  = col_q;
    word_o.run_index     = ord[3:0];
    word_o.run_bottom    = start_eff;
    word_o.run_top       = pixel_on_i ? row_q : row_q - 8'd1;
    word_o.run_overflow  = {2'b00, runs_q} >= OvfLim;
    word_o.max_runs_seen = max_new;
  end

  always_comb begin
    row_d    = row_q + 8'd1;
    col_d    = col_q;
    in_run_d = in_run_q;
    start_d  = start_eff;
    runs_d   = runs_q;
    max_d    = max_q;
    if (opening) begin
      in_run_d = 1'b1;
    end
    if (emit_o) begin
      in_run_d = 1'b0;
      runs_d   = cnt;
      max_d    = max_new;
    end
    if (col_end) begin
      row_d    = 8'd0;
      col_d    = col_wrap ? 10'd0 : col_next[9:0];
      in_run_d = 1'b0;
      runs_d   = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      in_run_q <= 1'b0;
      start_q  <= '0;
      runs_q   <= '0;
      max_q    <= '0;
    end else if (step_i) begin
      row_q    <= row_d;
      col_q    <= col_d;
      in_run_q <= in_run_d;
      start_q  <= start_d;
      runs_q   <= runs_d;
      max_q    <= max_d;
    end
  end

endmodule

@@ hdl/crs_out_reg.sv @@
// crs_out_reg: result register with valid/stall handshake toward the sink.
// Depends on crs_pkg.
module crs_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  crs_pkg::run_word_t word_i,
  input  logic               out_stall_i,
  output logic               free_o,
  output logic               out_valid_o,
  output crs_pkg::run_word_t word_o
);
  import crs_pkg::*;

  logic      valid_q, valid_d;
  run_word_t word_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

endmodule
